[src/lpfd_pkg.sv]
// ----------------------------------------------------------------------------
// lpfd_pkg
// Shared types and constants for the type/length prefixed frame delimiter.
// ----------------------------------------------------------------------------
package lpfd_pkg;

  localparam int FIELD_BYTES  = 4;
  localparam int HEADER_BYTES = 2 * FIELD_BYTES;
  localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);
  localparam int FLD_IDX_W    = (FIELD_BYTES > 1) ? $clog2(FIELD_BYTES) : 1;

  localparam logic [31:0] MAX_TYPE_RESET = 32'd15;

  typedef enum logic [1:0] {
    ST_HEADER    = 2'd0,
    ST_PAYLOAD   = 2'd1,
    ST_HEARTBEAT = 2'd2,
    ST_TYPE_ERR  = 2'd3
  } status_t;

  typedef struct packed {
    logic [HDR_IDX_W-1:0] header_index;
    logic [31:0]          type_accum;
    logic [31:0]          length_accum;
    logic [31:0]          payload_left;
    logic                 in_payload;
    logic                 error_latched;
  } state_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    status_t     status;
    logic        frame_last;
    logic [31:0] frame_type;
    logic [31:0] frame_length;
  } result_t;

endpackage

[src/lpfd_step.sv]
// ----------------------------------------------------------------------------
// lpfd_step
// Next-state and result logic for one stream byte: header assembly, payload
// countdown, heartbeat detection and the sticky type check.
// ----------------------------------------------------------------------------
module lpfd_step (
  input  lpfd_pkg::state_t  state_i,
  input  logic [7:0]        data_byte_i,
  input  logic [31:0]       max_type_i,
  output lpfd_pkg::state_t  state_o,
  output lpfd_pkg::result_t result_o
);
  import lpfd_pkg::*;

  logic [HDR_IDX_W-1:0] idx;
  logic [HDR_IDX_W-1:0] len_off;
  logic [FLD_IDX_W-1:0] len_pos;
  logic [31:0]          type_base;
  logic [31:0]          len_base;
  logic [31:0]          left_dec;
  status_t              status;
  logic                 last;

  assign idx     = state_i.header_index;
  assign len_off = idx - HDR_IDX_W'(FIELD_BYTES);
  assign len_pos = len_off[FLD_IDX_W-1:0];
  assign left_dec = state_i.payload_left - 32'd1;

  always_comb begin
    state_o   = state_i;
    status    = ST_HEADER;
    last      = 1'b0;
    type_base = 32'd0;
    len_base  = 32'd0;
    if (state_i.error_latched) begin
      status = ST_TYPE_ERR;
    end else if (state_i.in_payload) begin
      status               = ST_PAYLOAD;
      state_o.payload_left = left_dec;
      if (left_dec == 32'd0) begin
        last                 = 1'b1;
        state_o.in_payload   = 1'b0;
        state_o.header_index = '0;
      end
    end else begin
      // byte 0 of a header starts both fields from zero
      if (idx != '0) begin
        type_base = state_i.type_accum;
        len_base  = state_i.length_accum;
      end
      if (idx < HDR_IDX_W'(FIELD_BYTES)) begin
        state_o.type_accum   = type_base | (32'(data_byte_i) << {idx, 3'b000});
        state_o.length_accum = len_base;
      end else begin
        state_o.type_accum   = type_base;
        state_o.length_accum = len_base | (32'(data_byte_i) << {len_pos, 3'b000});
      end
      if (idx == HDR_IDX_W'(HEADER_BYTES - 1)) begin
        state_o.header_index = '0;
        if (state_o.type_accum > max_type_i) begin
          state_o.error_latched = 1'b1;
          status                = ST_TYPE_ERR;
        end else if (state_o.length_accum == 32'd0) begin
          status = ST_HEARTBEAT;
        end else begin
          state_o.in_payload   = 1'b1;
          state_o.payload_left = state_o.length_accum;
        end
      end else begin
        state_o.header_index = idx + HDR_IDX_W'(1);
      end
    end
  end

  assign result_o.byte_out     = data_byte_i;
  assign result_o.status       = status;
  assign result_o.frame_last   = last;
  assign result_o.frame_type   = state_o.type_accum;
  assign result_o.frame_length = state_o.length_accum;

endmodule

[src/length_prefixed_frame_delimiter_core.sv]
// ----------------------------------------------------------------------------
// length_prefixed_frame_delimiter_core
// Splits a byte stream into type/length prefixed frames and tags every byte.
//
//   channel  direction  ports
//   in       input      in_valid, in_ready, in_data_byte
//   out      output     out_valid, out_ready, out_byte_out, out_status,
//                       out_frame_last, out_frame_type, out_frame_length
//   cfg      input      cfg_valid, cfg_ready, cfg_data (max_type)
//
// One byte per cycle while the output drains: each accepted transaction updates
// the frame state and loads the result register in the same cycle.
// in_ready is high while the result register is empty or being drained, so a
// stalled output holds exactly one result and blocks further input.
// rst_n (synchronous) clears the frame state, the error flag and the output
// valid, and sets max_type to 15. cfg_ready is always high.
// ----------------------------------------------------------------------------
module length_prefixed_frame_delimiter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte_out,
  output logic [1:0]  out_status,
  output logic        out_frame_last,
  output logic [31:0] out_frame_type,
  output logic [31:0] out_frame_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);
  import lpfd_pkg::*;

  state_t      state_r;
  state_t      state_nxt;
  result_t     result_nxt;
  result_t     result_r;
  logic        out_valid_r;
  logic [31:0] max_type_r;
  logic        in_fire;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  lpfd_step u_step (
    .state_i     (state_r),
    .data_byte_i (in_data_byte),
    .max_type_i  (max_type_r),
    .state_o     (state_nxt),
    .result_o    (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
      max_type_r  <= MAX_TYPE_RESET;
    end else begin
      if (cfg_valid) begin
        max_type_r <= cfg_data;
      end
      if (in_fire) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload: load on every accepted transaction, hold otherwise
  always_ff @(posedge clk) begin
    if (in_fire) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte_out     = result_r.byte_out;
  assign out_status       = result_r.status;
  assign out_frame_last   = result_r.frame_last;
  assign out_frame_type   = result_r.frame_type;
  assign out_frame_length = result_r.frame_length;

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the type/length prefixed frame delimiter. A queued
// byte stream of headers, payloads and heartbeats is driven under random
// valid/ready gaps. Every output tag is compared against an in-bench
// delimiter model. The run steps max_type through several limits and ends
// on a rejected heartbeat that leaves the error latched.
// ----------------------------------------------------------------------------
module tb_top;
  import lpfd_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int TIMEOUT_CYCLES = 400000;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'd0;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [7:0]  out_byte_out;
  logic [1:0]  out_status;
  logic        out_frame_last;
  logic [31:0] out_frame_type;
  logic [31:0] out_frame_length;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data     = 32'd0;

  length_prefixed_frame_delimiter_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte_out     (out_byte_out),
    .out_status       (out_status),
    .out_frame_last   (out_frame_last),
    .out_frame_type   (out_frame_type),
    .out_frame_length (out_frame_length),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  // Delimiter model state
  logic [31:0]          type_limit = MAX_TYPE_RESET;
  logic [HDR_IDX_W-1:0] hdr_pos    = '0;
  logic [31:0]          type_acc   = '0;
  logic [31:0]          len_acc    = '0;
  logic [31:0]          bytes_left = '0;
  logic                 in_body    = 1'b0;
  logic                 type_err   = 1'b0;

  logic [7:0] stream_q[$];
  result_t    tag_q[$];

  int errors       = 0;
  int bytes_sent   = 0;
  int tags_checked = 0;
  int frame_ends   = 0;
  int heartbeats   = 0;
  int err_tags     = 0;
  int limit_writes = 0;
  int tx_gap       = 0;
  int rx_gap       = 0;
  int rx_hold_req  = 0;
  int rx_hold_ack  = 0;
  bit tx_idle_en   = 1'b1;
  bit rx_idle_en   = 1'b1;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic result_t delimit_byte(input logic [7:0] b);
    result_t r;
    int      pos;
    r.byte_out   = b;
    r.status     = ST_HEADER;
    r.frame_last = 1'b0;
    pos          = int'(hdr_pos);
    if (type_err) begin
      r.status = ST_TYPE_ERR;
    end else if (in_body) begin
      r.status   = ST_PAYLOAD;
      bytes_left = bytes_left - 32'd1;
      if (bytes_left == 32'd0) begin
        r.frame_last = 1'b1;
        in_body      = 1'b0;
        hdr_pos      = '0;
      end
    end else begin
      // header byte 0 starts a fresh header
      if (pos == 0) begin
        type_acc = '0;
        len_acc  = '0;
      end
      if (pos < FIELD_BYTES) type_acc |= 32'(b) << (8 * pos);
      else len_acc |= 32'(b) << (8 * (pos - FIELD_BYTES));
      if (pos == HEADER_BYTES - 1) begin
        hdr_pos = '0;
        // type check comes first, so a bad heartbeat is still an error
        if (type_acc > type_limit) begin
          type_err = 1'b1;
          r.status = ST_TYPE_ERR;
        end else if (len_acc == 32'd0) begin
          r.status = ST_HEARTBEAT;
        end else begin
          in_body    = 1'b1;
          bytes_left = len_acc;
        end
      end else begin
        hdr_pos = hdr_pos + 1'b1;
      end
    end
    r.frame_type   = type_acc;
    r.frame_length = len_acc;
    return r;
  endfunction

  function automatic void push_header(input logic [31:0] ftype, input logic [31:0] flen);
    for (int i = 0; i < FIELD_BYTES; i++) stream_q.push_back(ftype[8*i +: 8]);
    for (int i = 0; i < FIELD_BYTES; i++) stream_q.push_back(flen[8*i +: 8]);
  endfunction

  // Queue legal frames with random content until about target bytes are queued
  function automatic void push_frames(input int target);
    int          queued;
    int          pick;
    logic [31:0] ftype;
    logic [31:0] flen;
    queued = 0;
    while (queued < target) begin
      pick = $urandom_range(0, 99);
      if (type_limit == 32'hFFFF_FFFF) ftype = (pick < 10) ? 32'hFFFF_FFFF : $urandom;
      else if (pick < 20) ftype = type_limit;
      else ftype = $urandom_range(0, type_limit);
      pick = $urandom_range(0, 99);
      if (pick < 15) flen = 32'd0;
      else if (pick < 70) flen = $urandom_range(1, 8);
      else if (pick < 95) flen = $urandom_range(9, 40);
      else flen = $urandom_range(41, 300);
      push_header(ftype, flen);
      repeat (flen) stream_q.push_back(8'($urandom));
      queued += 8 + int'(flen);
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at tag %0d: %s", tags_checked, msg);
    errors++;
  endtask

  task automatic write_max_type(input logic [31:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    type_limit = v;
    limit_writes++;
  endtask

  // Hold until every queued byte is accepted and every tag has come back;
  // sample at the falling edge so the sender's updates have settled
  task automatic wait_drained();
    while (stream_q.size() != 0 || in_valid || tag_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        tag_q.push_back(delimit_byte(in_data_byte));
        bytes_sent++;
      end
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (stream_q.size() > 0) begin
          in_valid     <= 1'b1;
          in_data_byte <= stream_q.pop_front();
          if (tx_idle_en) tx_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_gap = 0;
    end else if (rx_hold_req != rx_hold_ack) begin
      rx_hold_ack = rx_hold_req;
      rx_gap      = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (rx_idle_en) rx_gap = pick_gap();
    end
  end

  // Result checker
  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (tag_q.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction, byte 0x%0h", out_byte_out));
      end else begin
        e = tag_q.pop_front();
        if (out_byte_out !== e.byte_out)
          report_mismatch($sformatf("byte_out 0x%0h, want 0x%0h", out_byte_out, e.byte_out));
        if (out_status !== e.status)
          report_mismatch($sformatf("status %0d, want %0d", out_status, e.status));
        if (out_frame_last !== e.frame_last)
          report_mismatch($sformatf("frame_last %0b, want %0b", out_frame_last, e.frame_last));
        if (out_frame_type !== e.frame_type)
          report_mismatch($sformatf("frame_type 0x%0h, want 0x%0h",
                                    out_frame_type, e.frame_type));
        if (out_frame_length !== e.frame_length)
          report_mismatch($sformatf("frame_length 0x%0h, want 0x%0h",
                                    out_frame_length, e.frame_length));
        if (e.frame_last) frame_ends++;
        if (e.status == ST_HEARTBEAT) heartbeats++;
        if (e.status == ST_TYPE_ERR) err_tags++;
      end
      tags_checked++;
    end
  end

  initial begin
    logic [31:0] lim;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Heartbeat at the reset limit, then one- and two-byte frames
    push_header(32'd15, 32'd0);
    push_header(32'd0, 32'd1);
    stream_q.push_back(8'hFF);
    push_header(32'd3, 32'd2);
    stream_q.push_back(8'h00);
    stream_q.push_back(8'h80);
    wait_drained();

    // Every type legal; stall the output long enough to back up the input
    write_max_type(32'hFFFF_FFFF);
    push_frames(200);
    repeat (30) @(posedge clk);
    rx_hold_req++;
    wait_drained();

    // Only type zero legal, back-to-back traffic
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    write_max_type(32'd0);
    push_frames(100);
    wait_drained();

    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    write_max_type($urandom_range(16, 65535));
    push_frames(120);
    wait_drained();

    // Finish on a heartbeat one above the limit; the error sticks for the tail
    lim = $urandom_range(32'h100, 32'hFFFF_FFFE);
    write_max_type(lim);
    push_frames(20);
    push_header(lim + 32'd1, 32'd0);
    repeat (30) stream_q.push_back(8'($urandom));
    wait_drained();
    repeat (10) @(posedge clk);

    $display("Checked %0d byte tags from %0d bytes across %0d max_type limits",
             tags_checked, bytes_sent, limit_writes + 1);
    $display("Covered %0d frame ends, %0d heartbeats, %0d bytes with the error latched",
             frame_ends, heartbeats, err_tags);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #(8 * TIMEOUT_CYCLES);
    $display("Timeout with %0d tags outstanding", tag_q.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

[length_prefixed_frame_delimiter_core.f]
src/lpfd_pkg.sv
src/lpfd_step.sv
src/length_prefixed_frame_delimiter_core.sv
verif/tb_top.sv
